// ----- rtl/spcr_pkg.sv -----
package spcr_pkg;

  // component and field widths
  localparam int CW   = 21;            // packed vector component
  localparam int SW   = CW - 1;        // unsigned radius / threshold
  localparam int MW   = 16;            // mass
  localparam int MSW  = MW + 1;        // mass sum
  localparam int DAMPW = 16;           // damping register
  localparam int FW   = DAMPW + 1;     // 65536 - damping

  // datapath widths
  localparam int DW    = CW + 1;           // centre or velocity difference
  localparam int D2W   = 2 * DW;           // squared distance
  localparam int DOTW  = 2 * DW + 1;       // signed dot product
  localparam int DMAGW = DOTW - 1;         // dot product magnitude
  localparam int DMW   = DW + MW;          // |d_i| * mass
  localparam int LOW   = DMW / 2;          // low split of the impulse product
  localparam int HIGH  = DMW - LOW;
  localparam int DENW  = MSW + D2W;        // (ma + mb) * dist2
  localparam int DDW   = DENW + 1;         // divisor, doubled
  localparam int NW    = DMAGW + DMW + 3;  // dividend with rounding term
  localparam int QW    = CW + 3;           // impulse magnitude
  localparam int VW    = QW + 2;           // velocity after impulse
  localparam int PRW   = VW + FW + 1;      // damped product
  localparam int MAGW  = PRW - DAMPW;      // damped magnitude
  localparam int SQW   = 2 * MAGW;
  localparam int LENW  = SQW + 2;
  localparam int THRW  = 2 * SW;

  localparam int VECW  = 3 * CW;
  localparam int NDIV  = 6;                // three for sphere a, three for b

  // stream layout
  localparam int IN_FIELDS_W  = 4 * VECW + 2 * SW + 2 * MW;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((2 * VECW + 7) / 8) * 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = SW;

  // pipeline depth
  localparam int FRONT_STAGES = 6;
  localparam int BACK_STAGES  = 5;
  localparam int PIPE_STAGES  = FRONT_STAGES + QW + BACK_STAGES;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DAMPING        = 1'b0,
    REG_REST_THRESHOLD = 1'b1
  } cfg_reg_e;

  typedef logic signed [CW-1:0] comp_t;

  typedef struct packed {
    logic [VECW-1:0] pos_a;
    logic [VECW-1:0] pos_b;
    logic [VECW-1:0] vel_a;
    logic [VECW-1:0] vel_b;
    logic [SW-1:0]   radius_a;
    logic [SW-1:0]   radius_b;
    logic [MW-1:0]   mass_a;
    logic [MW-1:0]   mass_b;
  } req_t;

  typedef struct packed {
    logic            coll;
    logic            zimp;
    logic [2:0]      neg;
    logic [VECW-1:0] vel_a;
    logic [VECW-1:0] vel_b;
  } side_t;

  typedef struct packed {
    logic            coll;
    logic [VECW-1:0] vel_a;
    logic [VECW-1:0] vel_b;
  } res_t;

  function automatic comp_t comp_of(logic [VECW-1:0] p, int k);
    return comp_t'(p[k*CW +: CW]);
  endfunction

  function automatic logic [DW-1:0] ext_comp(comp_t c);
    return {c[CW-1], c};
  endfunction

endpackage

// ----- rtl/spcr_front.sv -----
module spcr_front (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  spcr_pkg::req_t          req_i,
  output logic [spcr_pkg::NW-1:0] num_o [spcr_pkg::NDIV],
  output logic [spcr_pkg::DDW-1:0] den_o,
  output spcr_pkg::side_t         side_o
);
  import spcr_pkg::*;

  // stage 1: differences
  logic [DW-1:0]  d1_q [3];
  logic [DW-1:0]  w1_q [3];
  logic [SW:0]    rs1_q;
  logic [MW-1:0]  ma1_q, mb1_q;
  side_t          sd1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        d1_q[k] <= ext_comp(comp_of(req_i.pos_b, k)) - ext_comp(comp_of(req_i.pos_a, k));
        w1_q[k] <= ext_comp(comp_of(req_i.vel_a, k)) - ext_comp(comp_of(req_i.vel_b, k));
      end
      rs1_q       <= {1'b0, req_i.radius_a} + {1'b0, req_i.radius_b};
      ma1_q       <= req_i.mass_a;
      mb1_q       <= req_i.mass_b;
      sd1_q.coll  <= 1'b0;
      sd1_q.zimp  <= 1'b0;
      sd1_q.neg   <= '0;
      sd1_q.vel_a <= req_i.vel_a;
      sd1_q.vel_b <= req_i.vel_b;
    end
  end

  // stage 2: squares and dot terms
  logic signed [2*DW-1:0] dsq_c [3];
  logic signed [2*DW-1:0] wd_c  [3];
  logic [D2W-1:0]   dsq2_q [3];
  logic [2*DW-1:0]  wd2_q  [3];
  logic [DW-1:0]    absd2_q [3];
  logic [2:0]       dneg2_q;
  logic [2*SW+1:0]  rs2_q;
  logic [MSW-1:0]   msum2_q;
  logic [MW-1:0]    ma2_q, mb2_q;
  side_t            sd2_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsq_c[k] = $signed(d1_q[k]) * $signed(d1_q[k]);
      wd_c[k]  = $signed(w1_q[k]) * $signed(d1_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        dsq2_q[k]  <= $unsigned(dsq_c[k]);
        wd2_q[k]   <= $unsigned(wd_c[k]);
        absd2_q[k] <= d1_q[k][DW-1] ? (~d1_q[k] + DW'(1)) : d1_q[k];
        dneg2_q[k] <= d1_q[k][DW-1];
      end
      rs2_q   <= rs1_q * rs1_q;
      msum2_q <= {1'b0, ma1_q} + {1'b0, mb1_q};
      ma2_q   <= ma1_q;
      mb2_q   <= mb1_q;
      sd2_q   <= sd1_q;
    end
  end

  // stage 3: sums
  logic [D2W-1:0]   dist3_q;
  logic [DOTW-1:0]  dot3_q;
  logic [DW-1:0]    absd3_q [3];
  logic [2:0]       dneg3_q;
  logic [2*SW+1:0]  rs3_q;
  logic [MSW-1:0]   msum3_q;
  logic [MW-1:0]    ma3_q, mb3_q;
  side_t            sd3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist3_q <= dsq2_q[0] + dsq2_q[1] + dsq2_q[2];
      dot3_q  <= {wd2_q[0][2*DW-1], wd2_q[0]} + {wd2_q[1][2*DW-1], wd2_q[1]}
               + {wd2_q[2][2*DW-1], wd2_q[2]};
      absd3_q <= absd2_q;
      dneg3_q <= dneg2_q;
      rs3_q   <= rs2_q;
      msum3_q <= msum2_q;
      ma3_q   <= ma2_q;
      mb3_q   <= mb2_q;
      sd3_q   <= sd2_q;
    end
  end

  // stage 4: overlap test, mass terms, divisor
  logic [DOTW-1:0]  dot_neg_c;
  logic [DMAGW-1:0] dmag4_q;
  logic [DMW-1:0]   dm4_q [NDIV];
  logic [DENW-1:0]  den4_q;
  side_t            sd4_q;

  assign dot_neg_c = ~dot3_q + DOTW'(1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmag4_q <= dot3_q[DOTW-1] ? dot_neg_c[DMAGW-1:0] : dot3_q[DMAGW-1:0];
      for (int k = 0; k < 3; k++) begin
        dm4_q[k]     <= absd3_q[k] * mb3_q;
        dm4_q[k + 3] <= absd3_q[k] * ma3_q;
      end
      den4_q      <= msum3_q * dist3_q;
      sd4_q.vel_a <= sd3_q.vel_a;
      sd4_q.vel_b <= sd3_q.vel_b;
      sd4_q.coll  <= dist3_q < D2W'(rs3_q);
      sd4_q.zimp  <= (dist3_q == '0) || (msum3_q == '0);
      sd4_q.neg   <= dneg3_q ^ {3{dot3_q[DOTW-1]}};
    end
  end

  // stage 5: split impulse products
  logic [DMAGW+LOW-1:0]  plo5_q [NDIV];
  logic [DMAGW+HIGH-1:0] phi5_q [NDIV];
  logic [DENW-1:0]       den5_q;
  side_t                 sd5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NDIV; j++) begin
        plo5_q[j] <= dmag4_q * dm4_q[j][LOW-1:0];
        phi5_q[j] <= dmag4_q * dm4_q[j][DMW-1:LOW];
      end
      den5_q <= den4_q;
      sd5_q  <= sd4_q;
    end
  end

  // stage 6: dividend 4*num + den, divisor 2*den
  logic [NW-1:0]  num6_q [NDIV];
  logic [DDW-1:0] den6_q;
  side_t          sd6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NDIV; j++) begin
        num6_q[j] <= ((NW'(plo5_q[j]) + (NW'(phi5_q[j]) << LOW)) << 2) + NW'(den5_q);
      end
      den6_q <= {den5_q, 1'b0};
      sd6_q  <= sd5_q;
    end
  end

  assign num_o  = num6_q;
  assign den_o  = den6_q;
  assign side_o = sd6_q;

endmodule

// ----- rtl/spcr_divider.sv -----
module spcr_divider (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [spcr_pkg::NW-1:0]  num_i,
  input  logic [spcr_pkg::DDW-1:0] den_i,
  output logic [spcr_pkg::QW-1:0]  quo_o
);
  import spcr_pkg::*;

  logic [NW-1:0]  rem_q [QW-1];
  logic [DDW-1:0] den_q [QW-1];
  logic [QW-1:0]  quo_q [QW];

  // restoring division, one quotient bit per stage, msb first
  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [NW-1:0]  rem_in;
    logic [NW-1:0]  trial;
    logic [DDW-1:0] den_in;
    logic [QW-1:0]  quo_in;
    logic           fits;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = NW'(den_in) << (QW - 1 - s);
    assign fits  = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s] <= quo_in | (fits ? (QW'(1) << (QW - 1 - s)) : '0);
      end
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= fits ? (rem_in - trial) : rem_in;
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ----- rtl/spcr_back.sv -----
module spcr_back (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [spcr_pkg::QW-1:0]    quo_i [spcr_pkg::NDIV],
  input  spcr_pkg::side_t            side_i,
  input  logic [spcr_pkg::DAMPW-1:0] damping_i,
  input  logic [spcr_pkg::SW-1:0]    rest_i,
  output spcr_pkg::res_t             res_o
);
  import spcr_pkg::*;

  localparam logic [MAGW-1:0] SAT_HI = MAGW'((1 << (CW - 1)) - 1);
  localparam logic [MAGW-1:0] SAT_LO = MAGW'(1 << (CW - 1));

  // stage 1: apply impulse, a loses what b gains
  logic signed [VW-1:0] imp_c [3];
  logic signed [VW-1:0] v1_q  [NDIV];
  side_t                sd1_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (side_i.zimp) begin
        imp_c[k] = '0;
      end else if (side_i.neg[k]) begin
        imp_c[k] = -$signed(VW'(quo_i[k + 3]));
      end else begin
        imp_c[k] = $signed(VW'(quo_i[k + 3]));
      end
    end
  end

  logic signed [VW-1:0] impa_c [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (side_i.zimp) begin
        impa_c[k] = '0;
      end else if (side_i.neg[k]) begin
        impa_c[k] = -$signed(VW'(quo_i[k]));
      end else begin
        impa_c[k] = $signed(VW'(quo_i[k]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        v1_q[k]     <= VW'(comp_of(side_i.vel_a, k)) - impa_c[k];
        v1_q[k + 3] <= VW'(comp_of(side_i.vel_b, k)) + imp_c[k];
      end
      sd1_q <= side_i;
    end
  end

  // stage 2: damping product
  logic [FW-1:0]         keep_c;
  logic signed [PRW-1:0] prod2_q [NDIV];
  side_t                 sd2_q;

  assign keep_c = (FW'(1) << DAMPW) - FW'(damping_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NDIV; j++) begin
        prod2_q[j] <= v1_q[j] * $signed({1'b0, keep_c});
      end
      sd2_q <= sd1_q;
    end
  end

  // stage 3: round magnitude to nearest, ties away from zero
  logic [PRW-1:0]  aprod_c [NDIV];
  logic [PRW-1:0]  rnd_c   [NDIV];
  logic [MAGW-1:0] mag3_q  [NDIV];
  logic [NDIV-1:0] sgn3_q;
  side_t           sd3_q;

  always_comb begin
    for (int j = 0; j < NDIV; j++) begin
      aprod_c[j] = prod2_q[j][PRW-1] ? $unsigned(-prod2_q[j]) : $unsigned(prod2_q[j]);
      rnd_c[j]   = aprod_c[j] + (PRW'(1) << (DAMPW - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NDIV; j++) begin
        mag3_q[j] <= rnd_c[j][PRW-1:DAMPW];
        sgn3_q[j] <= prod2_q[j][PRW-1];
      end
      sd3_q <= sd2_q;
    end
  end

  // stage 4: squares, threshold square, saturated components
  logic [SQW-1:0]  sq4_q  [NDIV];
  comp_t           sat4_q [NDIV];
  logic [THRW-1:0] thr4_q;
  side_t           sd4_q;
  comp_t           sat_c  [NDIV];

  always_comb begin
    for (int j = 0; j < NDIV; j++) begin
      if (!sgn3_q[j]) begin
        sat_c[j] = (mag3_q[j] > SAT_HI) ? comp_t'(SAT_HI[CW-1:0]) : comp_t'(mag3_q[j][CW-1:0]);
      end else begin
        sat_c[j] = (mag3_q[j] > SAT_LO) ? comp_t'(SAT_LO[CW-1:0])
                                        : comp_t'(~mag3_q[j][CW-1:0] + CW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < NDIV; j++) begin
        sq4_q[j]  <= mag3_q[j] * mag3_q[j];
        sat4_q[j] <= sat_c[j];
      end
      thr4_q <= rest_i * rest_i;
      sd4_q  <= sd3_q;
    end
  end

  // stage 5: rest test, pack, pass-through when no overlap
  logic [LENW-1:0] len_a_c, len_b_c;
  logic            move_a_c, move_b_c;
  logic [VECW-1:0] pk_a_c, pk_b_c;
  res_t            res5_q;

  always_comb begin
    len_a_c  = LENW'(sq4_q[0]) + LENW'(sq4_q[1]) + LENW'(sq4_q[2]);
    len_b_c  = LENW'(sq4_q[3]) + LENW'(sq4_q[4]) + LENW'(sq4_q[5]);
    move_a_c = len_a_c > LENW'(thr4_q);
    move_b_c = len_b_c > LENW'(thr4_q);
    for (int k = 0; k < 3; k++) begin
      pk_a_c[k*CW +: CW] = move_a_c ? sat4_q[k]     : '0;
      pk_b_c[k*CW +: CW] = move_b_c ? sat4_q[k + 3] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res5_q.coll  <= sd4_q.coll;
      res5_q.vel_a <= sd4_q.coll ? pk_a_c : sd4_q.vel_a;
      res5_q.vel_b <= sd4_q.coll ? pk_b_c : sd4_q.vel_b;
    end
  end

  assign res_o = res5_q;

endmodule

// ----- rtl/sphere_pair_collision_response.sv -----
// channel   dir  signals                       contents
// s_axis    in   tvalid tready tdata[327:0]    one sphere pair request
// m_axis    out  tvalid tready tdata tuser     response velocities, overlap flag
// cfg       in   cfg_we_i cfg_index_i cfg_data_i  damping, rest threshold
//
// one pair enters per cycle while the pipeline is not held;
// the latency is set mostly by the impulse divider, one quotient bit per stage
// all stages advance together; a two-entry output buffer lets input continue
// while one response waits, and the pipeline holds only when both are full
// reset clears valid bits and empties the output buffer; damping resets to 0, rest threshold to 1
module sphere_pair_collision_response (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pos_a, pos_b, vel_a, vel_b, radius_a, radius_b, mass_a, mass_b, zero pad
  input  logic [spcr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // new_vel_a, new_vel_b, zero pad
  output logic [spcr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // collided
  output logic                               m_axis_tuser,
  input  logic                               cfg_we_i,
  input  logic [spcr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [spcr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import spcr_pkg::*;

  localparam int FIFO_DEPTH = 2;

  // request unpack
  req_t req;
  assign req.pos_a    = s_axis_tdata[0        +: VECW];
  assign req.pos_b    = s_axis_tdata[VECW     +: VECW];
  assign req.vel_a    = s_axis_tdata[2 * VECW +: VECW];
  assign req.vel_b    = s_axis_tdata[3 * VECW +: VECW];
  assign req.radius_a = s_axis_tdata[4 * VECW +: SW];
  assign req.radius_b = s_axis_tdata[4 * VECW + SW +: SW];
  assign req.mass_a   = s_axis_tdata[4 * VECW + 2 * SW +: MW];
  assign req.mass_b   = s_axis_tdata[4 * VECW + 2 * SW + MW +: MW];

  // config registers
  logic [DAMPW-1:0] damping_q;
  logic [SW-1:0]    rest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping_q <= '0;
      rest_q    <= SW'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DAMPING:        damping_q <= cfg_data_i[DAMPW-1:0];
        REG_REST_THRESHOLD: rest_q    <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance and valid bits
  logic [1:0]             cnt_q;
  logic                   adv;
  logic [PIPE_STAGES-1:0] valid_q;

  assign adv           = cnt_q != 2'(FIFO_DEPTH);
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[PIPE_STAGES-2:0], s_axis_tvalid};
    end
  end

  // datapath
  logic [NW-1:0]  num [NDIV];
  logic [DDW-1:0] den;
  side_t          side_front;
  logic [QW-1:0]  quo [NDIV];
  side_t          side_q [QW];
  res_t           res;

  spcr_front u_front (
    .clk_i  (clk_i),
    .en_i   (adv),
    .req_i  (req),
    .num_o  (num),
    .den_o  (den),
    .side_o (side_front)
  );

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    spcr_divider u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num[j]),
      .den_i (den),
      .quo_o (quo[j])
    );
  end

  // sideband delay alongside the divider
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_front;
      for (int s = 1; s < QW; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  spcr_back u_back (
    .clk_i     (clk_i),
    .en_i      (adv),
    .quo_i     (quo),
    .side_i    (side_q[QW-1]),
    .damping_i (damping_q),
    .rest_i    (rest_q),
    .res_o     (res)
  );

  // output buffer
  res_t fifo_q [FIFO_DEPTH];
  logic wr_ptr_q, rd_ptr_q;
  logic push, pop;

  assign push = adv && valid_q[PIPE_STAGES-1];
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tuser  = fifo_q[rd_ptr_q].coll;
  assign m_axis_tdata  = {{(OUT_TDATA_W - 2 * VECW){1'b0}},
                          fifo_q[rd_ptr_q].vel_b, fifo_q[rd_ptr_q].vel_a};

endmodule
